### rtl/fmhu_pkg.sv
// shared constants and types for the fm modulator with hold upsampler
package fmhu_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_RATIO_DEF   = 64;

  localparam int GAIN_BITS     = 31;
  localparam int RATIO_BITS    = 7;
  localparam int CFG_DATA_BITS = 31;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_GAIN = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_RATIO = 1'b1;

  localparam int TURN_BITS    = 32;
  localparam int CORDIC_BITS  = 32;
  localparam int CORDIC_STEPS = 24;

  typedef logic signed [CORDIC_BITS-1:0] cordic_t;

  localparam cordic_t CORDIC_START = 32'sd652032874;

  // arctangent of 2^-i, one full turn = 2^32
  localparam cordic_t ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  localparam int PHASE_RAM_DEPTH = 2;

endpackage

### rtl/fmhu_ifs.sv
// request channel interfaces: audio in, iq out, register writes
interface fmhu_in_if import fmhu_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_sample;
  logic                          start_of_burst;

  modport source (output valid, output audio_sample, output start_of_burst, input ready);
  modport sink   (input valid, input audio_sample, input start_of_burst, output ready);
endinterface

interface fmhu_out_if import fmhu_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_phase;
  logic signed [SAMPLE_BITS-1:0] quadrature;
  logic                          last_of_run;

  modport source (output valid, output in_phase, output quadrature, output last_of_run,
                  input ready);
  modport sink   (input valid, input in_phase, input quadrature, input last_of_run,
                  output ready);
endinterface

interface fmhu_cfg_if import fmhu_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/fmhu_ram.sv
// generic single-clock ram, one write port, one registered read port
module fmhu_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 2,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fm_modulator_with_hold_upsampler.sv
// fm modulator: phase accumulator in ram, pipelined cordic, hold repeater
//
//  channel | dir | payload                                  | handshake
//  in_ch   | in  | audio_sample, start_of_burst             | valid / ready
//  out_ch  | out | in_phase, quadrature, last_of_run        | valid / ready
//  cfg_ch  | in  | index, data (phase_gain, hold_ratio)     | valid / ready, ready always high
//
// a request's result passes the entry, cordic and quadrant map registers to the output
// register, which repeats it min(max(hold_ratio, 1), MAX_RATIO) times, one per cycle
// while out_ch.ready is high; sustained intake is set by the output repeater, which
// holds the pipeline until its last repeat is taken
// the whole pipeline advances together; a stalled output register holds every stage
// reset clears valids, the repeat count and phase_gain, sets hold_ratio to one; the
// phase reads as zero until its first write
module fm_modulator_with_hold_upsampler import fmhu_pkg::*; #(
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_RATIO   = MAX_RATIO_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fmhu_in_if.sink    in_ch,
  fmhu_out_if.source out_ch,
  fmhu_cfg_if.sink   cfg_ch
);

  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int CW        = $clog2(MAX_RATIO + 1);
  localparam int RND       = 31 - SAMPLE_BITS;
  localparam int MAP_BITS  = CORDIC_BITS + 1;
  localparam int SUM_BITS  = MAP_BITS + 1;
  localparam int PRAM_AW   = $clog2(PHASE_RAM_DEPTH);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  localparam logic signed [SUM_BITS-1:0] HALF_LSB = SUM_BITS'(2 ** (RND - 1));
  localparam logic signed [SUM_BITS-1:0] SAT_HI   = SUM_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO   = SUM_BITS'(-(2 ** (SAMPLE_BITS - 1)));

  // configuration registers
  logic [GAIN_BITS-1:0]  gain_r;
  logic [RATIO_BITS-1:0] ratio_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      ratio_r <= RATIO_BITS'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_PHASE_GAIN: gain_r  <= cfg_ch.data[GAIN_BITS-1:0];
        REG_HOLD_RATIO: ratio_r <= cfg_ch.data[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] ratio_eff;

  always_comb begin
    if (ratio_r == '0) begin
      ratio_eff = CW'(1);
    end else if (32'(ratio_r) > MAX_RATIO) begin
      ratio_eff = CW'(MAX_RATIO);
    end else begin
      ratio_eff = CW'(ratio_r);
    end
  end

  logic adv;
  assign in_ch.ready = adv;

  // entry stage: phase step product
  logic                        pv_r;
  logic                        start_r;
  logic signed [PROD_BITS-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      start_r <= in_ch.start_of_burst;
      prod_r  <= PROD_BITS'($signed(in_ch.audio_sample)) *
                 PROD_BITS'($signed({1'b0, gain_r}));
    end
  end

  // phase read-modify-write, last write forwarded past the ram read latency
  logic                  ram_we;
  logic [PHASE_BITS-1:0] ram_rdata;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] phase_use;
  logic [PHASE_BITS-1:0] phase_step;
  logic [PHASE_BITS-1:0] phase_wr;
  logic                  fwd_r;
  logic                  init_r;
  logic [PHASE_BITS-1:0] fwd_data_r;

  assign ram_we     = adv && pv_r;
  assign phase_cur  = !init_r ? '0 : (fwd_r ? fwd_data_r : ram_rdata);
  assign phase_use  = start_r ? '0 : phase_cur;
  assign phase_step = PHASE_BITS'(prod_r >>> (SAMPLE_BITS - 1));
  assign phase_wr   = phase_use + phase_step;

  fmhu_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (PHASE_RAM_DEPTH)
  ) u_phase_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PRAM_AW'(0)),
    .wdata (phase_wr),
    .raddr (PRAM_AW'(0)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= 1'b0;
      init_r <= 1'b0;
    end else begin
      fwd_r <= ram_we;
      if (ram_we) begin
        init_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_data_r <= phase_wr;
    end
  end

  // scale the phase to a 32-bit turn
  logic [TURN_BITS-1:0] turn;

  generate
    if (PHASE_BITS >= TURN_BITS) begin : g_turn_hi
      assign turn = phase_use[PHASE_BITS-1 -: TURN_BITS];
    end else begin : g_turn_pad
      assign turn = {phase_use, {(TURN_BITS - PHASE_BITS){1'b0}}};
    end
  endgenerate

  // cordic pipeline, one rotation per stage
  logic       cv_r [CORDIC_STEPS+1];
  cordic_t    cx_r [CORDIC_STEPS+1];
  cordic_t    cy_r [CORDIC_STEPS+1];
  cordic_t    cz_r [CORDIC_STEPS+1];
  logic [1:0] cq_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= CORDIC_START;
      cy_r[0] <= '0;
      cz_r[0] <= cordic_t'({2'b00, turn[TURN_BITS-3:0]});
      cq_r[0] <= turn[TURN_BITS-1 -: 2];
    end
  end

  generate
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      cordic_t dx;
      cordic_t dy;

      assign dx = cy_r[i] >>> i;
      assign dy = cx_r[i] >>> i;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cv_r[i+1] <= 1'b0;
        end else if (adv) begin
          cv_r[i+1] <= cv_r[i];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          cq_r[i+1] <= cq_r[i];
          if (!cz_r[i][CORDIC_BITS-1]) begin
            cx_r[i+1] <= cx_r[i] - dx;
            cy_r[i+1] <= cy_r[i] + dy;
            cz_r[i+1] <= cz_r[i] - ATAN_TURNS[i];
          end else begin
            cx_r[i+1] <= cx_r[i] + dx;
            cy_r[i+1] <= cy_r[i] - dy;
            cz_r[i+1] <= cz_r[i] + ATAN_TURNS[i];
          end
        end
      end
    end
  endgenerate

  // quadrant map
  logic                       mv_r;
  logic signed [MAP_BITS-1:0] mc_r;
  logic signed [MAP_BITS-1:0] ms_r;
  logic signed [MAP_BITS-1:0] fx;
  logic signed [MAP_BITS-1:0] fy;
  logic signed [MAP_BITS-1:0] mc;
  logic signed [MAP_BITS-1:0] ms;

  assign fx = MAP_BITS'(cx_r[CORDIC_STEPS]);
  assign fy = MAP_BITS'(cy_r[CORDIC_STEPS]);

  always_comb begin
    case (cq_r[CORDIC_STEPS])
      QUAD_I: begin
        mc = fx;
        ms = fy;
      end
      QUAD_II: begin
        mc = -fy;
        ms = fx;
      end
      QUAD_III: begin
        mc = -fx;
        ms = -fy;
      end
      default: begin
        mc = fy;
        ms = -fx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (adv) begin
      mv_r <= cv_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mc_r <= mc;
      ms_r <= ms;
    end
  end

  // round half up to the sample grid, then saturate
  function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic signed [MAP_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] r;
    sum = SUM_BITS'(v) + HALF_LSB;
    r   = sum >>> RND;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return SAMPLE_BITS'(r);
  endfunction

  // output register, repeats each result ratio times
  logic                   out_valid_r;
  logic [CW-1:0]          cnt_r;
  logic [SAMPLE_BITS-1:0] oc_r;
  logic [SAMPLE_BITS-1:0] os_r;
  logic                   last;
  logic                   load;

  assign last = (cnt_r == CW'(1));
  assign adv  = !mv_r || !out_valid_r || (out_ch.ready && last);
  assign load = adv && mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      cnt_r       <= ratio_eff;
    end else if (out_valid_r && out_ch.ready) begin
      if (last) begin
        out_valid_r <= 1'b0;
      end
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oc_r <= to_sample(mc_r);
      os_r <= to_sample(ms_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.in_phase    = oc_r;
  assign out_ch.quadrature  = os_r;
  assign out_ch.last_of_run = last;

endmodule
